// File: design/tdsg_pkg.sv
// Package for the three-phase sine duty generator: constants, register codes
// and the elaboration-time Q30 sine and cosine series used to build the sine table.
// Depends on nothing.
`default_nettype none

package tdsg_pkg;

  // Default geometry and reset values.
  localparam int DEGREES_PER_TURN_DEF = 360;
  localparam int DUTY_WIDTH_DEF       = 16;
  localparam int MAX_DUTY_RESET       = 7500;
  localparam int PHASE_STEP_RESET     = 30;

  // Fixed field widths.
  localparam int OUT_DUTY_W  = 16;
  localparam int ANGLE_OUT_W = 9;
  localparam int STEP_W      = 9;
  localparam int OFFSET_W    = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  // Fixed-point constants for the table build.
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q15_CAP     = 64'd32767;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MAX_DUTY   = 2'd0,
    REG_PHASE_STEP = 2'd1
  } cfg_reg_t;

  // Q30 sine of x for 0 <= x < pi/2; every product is truncated.
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    x2  = (x * x) >> 30;
    t   = x;
    pos = x;
    neg = 64'd0;
    t   = ((t * x2) >> 30) / 64'd6;
    neg = neg + t;
    t   = ((t * x2) >> 30) / 64'd20;
    pos = pos + t;
    t   = ((t * x2) >> 30) / 64'd42;
    neg = neg + t;
    t   = ((t * x2) >> 30) / 64'd72;
    pos = pos + t;
    t   = ((t * x2) >> 30) / 64'd110;
    neg = neg + t;
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // Q30 cosine of x for 0 <= x < pi/2; every product is truncated.
  function automatic logic [63:0] cos_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    x2  = (x * x) >> 30;
    t   = Q30_ONE;
    pos = Q30_ONE;
    neg = 64'd0;
    t   = ((t * x2) >> 30) / 64'd2;
    neg = neg + t;
    t   = ((t * x2) >> 30) / 64'd12;
    pos = pos + t;
    t   = ((t * x2) >> 30) / 64'd30;
    neg = neg + t;
    t   = ((t * x2) >> 30) / 64'd56;
    pos = pos + t;
    t   = ((t * x2) >> 30) / 64'd90;
    neg = neg + t;
    t   = ((t * x2) >> 30) / 64'd132;
    pos = pos + t;
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

endpackage

`default_nettype wire

// File: design/tdsg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module tdsg_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 360,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/three_phase_sine_duty_generator.sv
// Top level of the three-phase sine duty generator: angle register, sine RAMs,
// duty multipliers and the output register.
// Depends on tdsg_pkg and tdsg_ram.
`default_nettype none

// Each accepted request with tick high produces one result holding three PWM compare
// values, floor(offset_sine * max_duty / 65536) at the current angle and at one and two
// thirds of a turn ahead, together with the angle used; the angle then advances by
// the phase step modulo DEGREES_PER_TURN. A request is taken every clock cycle while
// in_stall is low; its result passes through the registered read of the three sine
// RAMs and then the multiply into the output register. The output register and the
// RAM read stage are separately enabled, so a new request is still taken while a
// finished result waits on out_stall, as long as the read stage is empty. After reset
// the block loads the sine table into its RAMs and in_stall stays high until every entry
// is written; configuration writes are taken at any time and cfg_ready is always high.
module three_phase_sine_duty_generator
  import tdsg_pkg::*;
#(
  parameter int DEGREES_PER_TURN = DEGREES_PER_TURN_DEF,
  parameter int DUTY_WIDTH       = DUTY_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Request channel
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire logic                   tick,
  // Result channel
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      logic [OUT_DUTY_W-1:0]  duty_a,
  output      logic [OUT_DUTY_W-1:0]  duty_b,
  output      logic [OUT_DUTY_W-1:0]  duty_c,
  output      logic [ANGLE_OUT_W-1:0] phase_angle,
  // Configuration write channel
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire cfg_reg_t               cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int ANGLE_W    = $clog2(DEGREES_PER_TURN);
  localparam int THIRD      = DEGREES_PER_TURN / 3;
  localparam int TWO_THIRDS = (2 * DEGREES_PER_TURN) / 3;
  localparam int STEP_RESET = PHASE_STEP_RESET % DEGREES_PER_TURN;
  localparam int PROD_W     = OFFSET_W + DUTY_WIDTH;

  // Reduce a raw step modulo the turn by conditional subtraction of shifted turns.
  function automatic logic [ANGLE_W-1:0] reduce_step(input logic [STEP_W-1:0] v);
    logic [STEP_W:0] r;
    r = {1'b0, v};
    for (int k = STEP_W - 1; k >= 0; k--) begin
      if ((DEGREES_PER_TURN << k) < (1 << STEP_W)) begin
        if (int'(r) >= (DEGREES_PER_TURN << k)) begin
          r = r - (STEP_W + 1)'(DEGREES_PER_TURN << k);
        end
      end
    end
    return ANGLE_W'(r);
  endfunction

  // Add an offset to an angle and wrap once into the turn.
  function automatic logic [ANGLE_W-1:0] wrap_add(input logic [ANGLE_W-1:0] a,
                                                  input logic [ANGLE_W-1:0] b);
    logic [ANGLE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (int'(s) >= DEGREES_PER_TURN) begin
      s = s - (ANGLE_W + 1)'(DEGREES_PER_TURN);
    end
    return ANGLE_W'(s);
  endfunction

  // Configuration and angle state.
  logic [DUTY_WIDTH-1:0] max_duty;
  logic [ANGLE_W-1:0]    phase_step;
  logic [ANGLE_W-1:0]    angle_reg;

  // Table load sweep.
  logic                  filling;
  logic [ANGLE_W-1:0]    fill_addr;

  // Pipeline control and payload.
  logic                  s1_valid;
  logic [ANGLE_W-1:0]    s1_angle;
  logic                  out_load;
  logic                  s1_adv;
  logic                  accept;
  logic                  fire;

  // RAM addresses and read data.
  logic [ANGLE_W-1:0]    addr_a;
  logic [ANGLE_W-1:0]    addr_b;
  logic [ANGLE_W-1:0]    addr_c;
  logic [OFFSET_W-1:0]   rd_a;
  logic [OFFSET_W-1:0]   rd_b;
  logic [OFFSET_W-1:0]   rd_c;
  logic [PROD_W-1:0]     prod_a;
  logic [PROD_W-1:0]     prod_b;
  logic [PROD_W-1:0]     prod_c;

  // Sine table in offset form (s + 32768), built at elaboration.
  logic [OFFSET_W-1:0]   rom_table [DEGREES_PER_TURN];

  for (genvar g = 0; g < DEGREES_PER_TURN; g++) begin : g_rom
    localparam int U    = 4 * g;
    localparam int QUAD = (U / DEGREES_PER_TURN) % 4;
    localparam int REM  = U % DEGREES_PER_TURN;
    localparam logic [63:0] THETA   = (64'(REM) * HALF_PI_Q30) / 64'(DEGREES_PER_TURN);
    localparam logic [63:0] V       = (QUAD % 2 == 1) ? cos_q30(THETA) : sin_q30(THETA);
    localparam logic [63:0] MAG_RAW = (V + 64'd16384) >> 15;
    localparam logic [63:0] MAG     = (MAG_RAW > Q15_CAP) ? Q15_CAP : MAG_RAW;
    localparam logic [OFFSET_W-1:0] ENTRY = (QUAD >= 2) ? OFFSET_W'(64'd32768 - MAG)
                                                        : OFFSET_W'(64'd32768 + MAG);
    assign rom_table[g] = ENTRY;
  end

  // Handshake: the output register and the read stage have separate enables.
  assign out_load  = !out_valid || !out_stall;
  assign s1_adv    = !s1_valid || out_load;
  assign in_stall  = filling || !s1_adv;
  assign accept    = in_valid && !in_stall;
  assign fire      = accept && tick;
  assign cfg_ready = 1'b1;

  // Phase addresses for the current angle.
  assign addr_a = angle_reg;
  assign addr_b = wrap_add(angle_reg, ANGLE_W'(THIRD));
  assign addr_c = wrap_add(angle_reg, ANGLE_W'(TWO_THIRDS));

  // One sine RAM per phase, all loaded by the same sweep.
  tdsg_ram #(.WIDTH(OFFSET_W), .DEPTH(DEGREES_PER_TURN)) u_ram_a (
    .clk     (clk),
    .wr_en   (filling),
    .wr_addr (fill_addr),
    .wr_data (rom_table[fill_addr]),
    .rd_en   (s1_adv),
    .rd_addr (addr_a),
    .rd_data (rd_a)
  );

  tdsg_ram #(.WIDTH(OFFSET_W), .DEPTH(DEGREES_PER_TURN)) u_ram_b (
    .clk     (clk),
    .wr_en   (filling),
    .wr_addr (fill_addr),
    .wr_data (rom_table[fill_addr]),
    .rd_en   (s1_adv),
    .rd_addr (addr_b),
    .rd_data (rd_b)
  );

  tdsg_ram #(.WIDTH(OFFSET_W), .DEPTH(DEGREES_PER_TURN)) u_ram_c (
    .clk     (clk),
    .wr_en   (filling),
    .wr_addr (fill_addr),
    .wr_data (rom_table[fill_addr]),
    .rd_en   (s1_adv),
    .rd_addr (addr_c),
    .rd_data (rd_c)
  );

  // Scale each offset sine by the full-scale duty.
  assign prod_a = PROD_W'(rd_a) * PROD_W'(max_duty);
  assign prod_b = PROD_W'(rd_b) * PROD_W'(max_duty);
  assign prod_c = PROD_W'(rd_c) * PROD_W'(max_duty);

  // Table load sweep after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      filling   <= 1'b1;
      fill_addr <= '0;
    end else if (filling) begin
      if (int'(fill_addr) == DEGREES_PER_TURN - 1) begin
        filling <= 1'b0;
      end else begin
        fill_addr <= fill_addr + ANGLE_W'(1);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_duty   <= DUTY_WIDTH'(MAX_DUTY_RESET);
      phase_step <= ANGLE_W'(STEP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_MAX_DUTY:   max_duty   <= cfg_wdata[DUTY_WIDTH-1:0];
        REG_PHASE_STEP: phase_step <= reduce_step(cfg_wdata[STEP_W-1:0]);
        default: ;
      endcase
    end
  end

  // Angle advances once per request with tick high.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_reg <= '0;
    end else if (fire) begin
      angle_reg <= wrap_add(angle_reg, phase_step);
    end
  end

  // Read stage: tracks the RAM output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_angle <= angle_reg;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      duty_a      <= OUT_DUTY_W'(prod_a[PROD_W-1:OFFSET_W]);
      duty_b      <= OUT_DUTY_W'(prod_b[PROD_W-1:OFFSET_W]);
      duty_c      <= OUT_DUTY_W'(prod_c[PROD_W-1:OFFSET_W]);
      phase_angle <= ANGLE_OUT_W'(s1_angle);
    end
  end

endmodule

`default_nettype wire
